// ----- rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket deframer/unmask unit.
`default_nettype none

package wsd_pkg;

  // Receive frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended-length and key byte counts, minus one
  localparam logic [2:0] CNT_EXT16 = 3'd1;
  localparam logic [2:0] CNT_EXT64 = 3'd7;
  localparam logic [2:0] CNT_KEY   = 3'd3;

  // Message classes
  localparam logic [1:0] MT_TEXT  = 2'd0;
  localparam logic [1:0] MT_BIN   = 2'd1;
  localparam logic [1:0] MT_CLOSE = 2'd2;

  localparam int unsigned MAXLEN_W = 63;
  localparam int unsigned LEN_W    = 64;

  // Result queue between parser and output stage
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    EV_DATA,
    EV_PING,
    EV_PONG,
    EV_ERROR,
    EV_CLOSED
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_PROTOCOL,
    ERR_OPCODE,
    ERR_OVERSIZE,
    ERR_CONT
  } err_e;

  // One classified result on its way to the output stage; data still masked
  typedef struct packed {
    event_e     kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic       present;
    logic [1:0] mtype;
    logic       msg_end;
    err_e       err;
  } uop_t;

endpackage

`default_nettype wire

// ----- rtl/wsd_front.sv -----
// Frame parser: header, length and key tracking, result classification.
`default_nettype none

module wsd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              cfg_we_i,
  input  logic [wsd_pkg::MAXLEN_W-1:0]      cfg_max_payload_length_i,
  output logic                              push_o,
  output wsd_pkg::uop_t                     uop_o
);
  import wsd_pkg::*;

  phase_e              phase_q, phase_d;
  logic                fin_q, fin_d;
  logic [3:0]          op_q, op_d;
  logic                rsv_q, rsv_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [31:0]         key_q, key_d;
  logic [1:0]          kidx_q, kidx_d;
  logic                frag_q, frag_d;
  logic [1:0]          mtype_q, mtype_d;
  logic                skip_q, skip_d;
  logic                closed_q, closed_d;
  logic [MAXLEN_W-1:0] maxlen_q;

  logic       acc;
  logic       rem_zero;
  logic       rem_last;
  logic       hdr_bad;
  logic       supported;
  logic       oversize;
  logic       is_ctl;
  logic [1:0] key_sel;
  logic [7:0] key_byte;
  logic [1:0] new_mtype;

  assign acc       = in_valid_i && !in_stall_i && !closed_q;
  assign rem_zero  = (rem_q == '0);
  assign rem_last  = (rem_q == LEN_W'(1));
  assign hdr_bad   = !rx_byte_i[7] || rsv_q;
  assign supported = op_q inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};
  assign oversize  = rem_q > {1'b0, maxlen_q};
  assign is_ctl    = (op_q == OP_PING) || (op_q == OP_PONG);
  assign key_sel   = 2'd3 - kidx_q;
  assign key_byte  = key_q[{key_sel, 3'b000} +: 8];

  always_comb begin
    new_mtype = mtype_q;
    if (op_q == OP_TEXT) new_mtype = MT_TEXT;
    else if (op_q == OP_BIN) new_mtype = MT_BIN;
  end

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      case (phase_q)
        PH_HDR0: phase_d = PH_HDR1;
        PH_HDR1: begin
          if (hdr_bad) phase_d = PH_HDR0;
          else if (rx_byte_i[6:0] == LEN_EXT16 || rx_byte_i[6:0] == LEN_EXT64)
            phase_d = PH_EXTLEN;
          else phase_d = PH_KEY;
        end
        PH_EXTLEN: begin
          if (cnt_q == '0) phase_d = PH_KEY;
        end
        PH_KEY: begin
          if (cnt_q == '0) phase_d = rem_zero ? PH_HDR0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (rem_zero || rem_last) phase_d = PH_HDR0;
        end
        default: phase_d = PH_HDR0;
      endcase
    end
  end

  // Frame state and result classification
  always_comb begin
    fin_d    = fin_q;
    op_d     = op_q;
    rsv_d    = rsv_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    frag_d   = frag_q;
    mtype_d  = mtype_q;
    skip_d   = skip_q;
    closed_d = closed_q;
    push_o   = 1'b0;
    uop_o    = '0;
    if (acc) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d = rx_byte_i[7];
          rsv_d = |rx_byte_i[6:4];
          op_d  = rx_byte_i[3:0];
        end
        PH_HDR1: begin
          if (hdr_bad) begin
            closed_d  = 1'b1;
            push_o    = 1'b1;
            uop_o.kind = EV_ERROR;
            uop_o.err  = ERR_PROTOCOL;
          end else begin
            key_d = '0;
            if (rx_byte_i[6:0] == LEN_EXT16) begin
              rem_d = '0;
              cnt_d = CNT_EXT16;
            end else if (rx_byte_i[6:0] == LEN_EXT64) begin
              rem_d = '0;
              cnt_d = CNT_EXT64;
            end else begin
              rem_d = LEN_W'(rx_byte_i[6:0]);
              cnt_d = CNT_KEY;
            end
          end
        end
        PH_EXTLEN: begin
          rem_d = {rem_q[LEN_W-9:0], rx_byte_i};
          cnt_d = (cnt_q == '0) ? CNT_KEY : cnt_q - 3'd1;
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 3'd1;
          end else begin
            // header complete: checks in priority order
            kidx_d = '0;
            skip_d = 1'b0;
            if (!supported || oversize || (op_q == OP_CONT && !frag_q && !is_ctl)) begin
              skip_d     = !rem_zero;
              push_o     = 1'b1;
              uop_o.kind = EV_ERROR;
              if (!supported) uop_o.err = ERR_OPCODE;
              else if (oversize) uop_o.err = ERR_OVERSIZE;
              else uop_o.err = ERR_CONT;
            end else if (is_ctl) begin
              if (rem_zero) begin
                push_o     = 1'b1;
                uop_o.kind = (op_q == OP_PING) ? EV_PING : EV_PONG;
              end
            end else if (op_q == OP_CLOSE) begin
              mtype_d = MT_CLOSE;
              if (rem_zero) begin
                closed_d      = 1'b1;
                push_o        = 1'b1;
                uop_o.kind    = EV_CLOSED;
                uop_o.mtype   = MT_CLOSE;
                uop_o.msg_end = 1'b1;
              end
            end else begin
              mtype_d = new_mtype;
              frag_d  = !fin_q;
              if (rem_zero && fin_q) begin
                push_o        = 1'b1;
                uop_o.kind    = EV_DATA;
                uop_o.mtype   = new_mtype;
                uop_o.msg_end = 1'b1;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (!rem_zero) begin
            rem_d = rem_q - LEN_W'(1);
            if (skip_q) begin
              if (rem_last) skip_d = 1'b0;
            end else if (is_ctl) begin
              if (rem_last) begin
                push_o     = 1'b1;
                uop_o.kind = (op_q == OP_PING) ? EV_PING : EV_PONG;
              end
            end else begin
              kidx_d        = kidx_q + 2'd1;
              push_o        = 1'b1;
              uop_o.raw     = rx_byte_i;
              uop_o.key     = key_byte;
              uop_o.present = 1'b1;
              if (op_q == OP_CLOSE) begin
                uop_o.kind    = rem_last ? EV_CLOSED : EV_DATA;
                uop_o.mtype   = MT_CLOSE;
                uop_o.msg_end = rem_last;
                closed_d      = rem_last;
              end else begin
                uop_o.kind    = EV_DATA;
                uop_o.mtype   = mtype_q;
                uop_o.msg_end = rem_last && fin_q;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      fin_q    <= 1'b0;
      op_q     <= '0;
      rsv_q    <= 1'b0;
      rem_q    <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      kidx_q   <= '0;
      frag_q   <= 1'b0;
      mtype_q  <= '0;
      skip_q   <= 1'b0;
      closed_q <= 1'b0;
      maxlen_q <= '1;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      rsv_q    <= rsv_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
      frag_q   <= frag_d;
      mtype_q  <= mtype_d;
      skip_q   <= skip_d;
      closed_q <= closed_d;
      if (cfg_we_i) maxlen_q <= cfg_max_payload_length_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wsd_fifo.sv -----
// Short result queue between the parser and the output stage.
`default_nettype none

module wsd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::uop_t din_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          nempty_o,
  output wsd_pkg::uop_t dout_o,
  output logic          overflow_o
);
  import wsd_pkg::*;

  uop_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign nempty_o   = (cnt_q != '0);
  assign dout_o     = mem_q[rptr_q];
  assign do_pop     = pop_i && nempty_o;
  assign overflow_o = push_i && full_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (!push_i && do_pop) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      if (do_pop) rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wsd_back.sv -----
// Output stage: unmasks payload bytes and holds the result register.
`default_nettype none

module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_nempty_i,
  input  wsd_pkg::uop_t q_dout_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    event_kind_o,
  output logic [7:0]    payload_data_o,
  output logic          data_present_o,
  output logic [1:0]    message_type_o,
  output logic          message_end_o,
  output logic [2:0]    error_code_o
);
  import wsd_pkg::*;

  logic       vld_q;
  logic [2:0] kind_q;
  logic [7:0] data_q;
  logic       pres_q;
  logic [1:0] mtype_q;
  logic       end_q;
  logic [2:0] err_q;
  logic       load;

  assign load    = q_nempty_i && (!vld_q || !out_stall_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!vld_q || !out_stall_i) begin
      vld_q <= q_nempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= q_dout_i.kind;
      data_q  <= q_dout_i.present ? (q_dout_i.raw ^ q_dout_i.key) : 8'h00;
      pres_q  <= q_dout_i.present;
      mtype_q <= q_dout_i.mtype;
      end_q   <= q_dout_i.msg_end;
      err_q   <= q_dout_i.err;
    end
  end

  assign out_valid_o    = vld_q;
  assign event_kind_o   = kind_q;
  assign payload_data_o = data_q;
  assign data_present_o = pres_q;
  assign message_type_o = mtype_q;
  assign message_end_o  = end_q;
  assign error_code_o   = err_q;

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_deframer_unmask_unit.sv -----
// Top level of the WebSocket receive deframer with payload unmasking.
//
// Input channel: one received byte per transaction on rx_byte_i, taken at a
// rising edge with in_valid_i high and in_stall_o low. Each byte yields zero
// or one result on the output channel (out_valid_o / out_stall_i): payload
// bytes unmasked, ping/pong events, errors and the close event.
// Config channel: cfg_valid_i / cfg_ready_o writes max_payload_length; it is
// always ready and should only be written while the block is idle.
// Throughput: one byte per cycle while in_stall_o is low, set by the parser's
// state loop; the 64-bit length decrement and the oversize compare sit in that loop.
// Path: a result is written into the queue at the edge that takes its byte,
// then loaded into the output register that drives out_valid_o once it is free.
// Stalls: while out_stall_i is high the output register holds; the queue
// absorbs up to two more results, then in_stall_o rises until space frees.
// Reset: parser returns to the first header byte, the connection is open,
// queue and output register are empty, max_payload_length is 2^63-1.
// After a protocol error or a close frame the block drops all input bytes
// silently until the next reset.
`default_nettype none

module websocket_frame_deframer_unmask_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wsd_pkg::MAXLEN_W-1:0] cfg_max_payload_length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   event_kind_o,
  output logic [7:0]                   payload_data_o,
  output logic                         data_present_o,
  output logic [1:0]                   message_type_o,
  output logic                         message_end_o,
  output logic [2:0]                   error_code_o
);
  import wsd_pkg::*;

  logic push;
  uop_t push_uop;
  logic q_full;
  logic q_nempty;
  uop_t q_dout;
  logic q_pop;
  logic q_overflow;

  assign cfg_ready_o = 1'b1;
  // Parser stalls only when the queue has no room for a possible result
  assign in_stall_o  = q_full;

  wsd_front u_front (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_stall_i               (in_stall_o),
    .rx_byte_i                (rx_byte_i),
    .cfg_we_i                 (cfg_valid_i && cfg_ready_o),
    .cfg_max_payload_length_i (cfg_max_payload_length_i),
    .push_o                   (push),
    .uop_o                    (push_uop)
  );

  wsd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .din_i      (push_uop),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .nempty_o   (q_nempty),
    .dout_o     (q_dout),
    .overflow_o (q_overflow)
  );

  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_nempty_i     (q_nempty),
    .q_dout_i       (q_dout),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .payload_data_o (payload_data_o),
    .data_present_o (data_present_o),
    .message_type_o (message_type_o),
    .message_end_o  (message_end_o),
    .error_code_o   (error_code_o)
  );

  // The parser must never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_overflow)
    else $error("result queue overflow");

  // Data only travels with payload or close events
  a_data_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_present_o |->
      (event_kind_o == EV_DATA) || (event_kind_o == EV_CLOSED))
    else $error("data on a non-payload event");

  // Error code present exactly on error events
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_kind_o == EV_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code and event kind disagree");

  // A queued result reaches the output register as soon as it is free
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_nempty && !out_valid_o |=> out_valid_o)
    else $error("output stage failed to load a queued result");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the receive-side frame deframer with payload unmasking.
`timescale 1ns / 1ps

module tb_top;
  import wsd_pkg::*;

  // One result as the block presents it on the output channel
  typedef struct packed {
    event_e     kind;
    logic [7:0] data;
    logic       present;
    logic [1:0] mtype;
    logic       msg_end;
    err_e       err;
  } deframe_result_t;

  localparam deframe_result_t NO_RESULT = '{kind: EV_DATA, data: 8'h00, present: 1'b0,
                                            mtype: MT_TEXT, msg_end: 1'b0, err: ERR_NONE};

  // One row of the directed script: a byte and, where obvious, its result
  typedef struct {
    logic [7:0]      b;
    bit              typed;
    deframe_result_t res;
  } script_row_t;

  // DUT pins; every input starts at a known value
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i   = 8'h00;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [MAXLEN_W-1:0] cfg_max_payload_length_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          event_kind_o;
  logic [7:0]          payload_data_o;
  logic                data_present_o;
  logic [1:0]          message_type_o;
  logic                message_end_o;
  logic [2:0]          error_code_o;

  // Predictor state, mirrors the parser after every accepted byte
  logic [62:0] len_limit   = {63{1'b1}};
  phase_e      parse_ph    = PH_HDR0;
  logic        hdr_fin     = 1'b0;
  logic        hdr_rsv     = 1'b0;
  logic [3:0]  hdr_op      = OP_CONT;
  logic [63:0] len_left    = '0;
  logic [2:0]  ext_cnt     = '0;
  logic [31:0] mask_word   = '0;
  logic [1:0]  key_pos     = '0;
  logic        frag_open   = 1'b0;
  logic [1:0]  msg_cls     = MT_TEXT;
  logic        skip_body   = 1'b0;
  logic        conn_closed = 1'b0;

  deframe_result_t rx_events_due [$];   // results owed by the block, oldest first
  script_row_t     script [$];
  int unsigned     bytes_sent  = 0;
  int unsigned     results_seen = 0;
  int unsigned     kind_seen [8] = '{default: 0};
  int unsigned     mismatches  = 0;
  bit              calm_in     = 1'b0;  // stretches with no sender gaps
  bit              calm_out    = 1'b0;  // stretches with no receiver stalls

  websocket_frame_deframer_unmask_unit i_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .rx_byte_i                (rx_byte_i),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_max_payload_length_i (cfg_max_payload_length_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .event_kind_o             (event_kind_o),
    .payload_data_o           (payload_data_o),
    .data_present_o           (data_present_o),
    .message_type_o           (message_type_o),
    .message_end_o            (message_end_o),
    .error_code_o             (error_code_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Error with a payload behind it: the payload is swallowed silently
  function automatic void start_skip();
    skip_body = (len_left != '0);
    if (len_left == '0) parse_ph = PH_HDR0;
  endfunction

  // Advance the parser by one received byte; returns 1 when a result is owed
  function automatic bit deframe_byte(input logic [7:0] b, output deframe_result_t r);
    logic last;
    r = NO_RESULT;
    if (conn_closed) return 1'b0;   // sticky until reset
    case (parse_ph)
      PH_HDR0: begin
        hdr_fin  = b[7];
        hdr_rsv  = |b[6:4];
        hdr_op   = b[3:0];
        parse_ph = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        // unmasked frame or reserved bits set: error, then closed for good
        if (!b[7] || hdr_rsv) begin
          conn_closed = 1'b1;
          parse_ph    = PH_HDR0;
          r.kind      = EV_ERROR;
          r.err       = ERR_PROTOCOL;
          return 1'b1;
        end
        mask_word = '0;
        len_left  = '0;
        if (b[6:0] == LEN_EXT16) begin
          ext_cnt  = CNT_EXT16;
          parse_ph = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_cnt  = CNT_EXT64;
          parse_ph = PH_EXTLEN;
        end else begin
          len_left = 64'(b[6:0]);
          ext_cnt  = CNT_KEY;
          parse_ph = PH_KEY;
        end
        return 1'b0;
      end
      PH_EXTLEN: begin
        len_left = {len_left[55:0], b};   // big-endian
        if (ext_cnt == '0) begin
          ext_cnt  = CNT_KEY;
          parse_ph = PH_KEY;
        end else begin
          ext_cnt = ext_cnt - 3'd1;
        end
        return 1'b0;
      end
      PH_KEY: begin
        mask_word = {mask_word[23:0], b};
        if (ext_cnt != '0) begin
          ext_cnt = ext_cnt - 3'd1;
          return 1'b0;
        end
        // header complete: opcode check, then length, then frame kind
        parse_ph  = PH_PAYLOAD;
        key_pos   = '0;
        skip_body = 1'b0;
        if (!(hdr_op <= OP_BIN || hdr_op == OP_CLOSE || hdr_op == OP_PING ||
              hdr_op == OP_PONG)) begin
          start_skip();
          r.kind = EV_ERROR;
          r.err  = ERR_OPCODE;
          return 1'b1;
        end
        if (len_left > {1'b0, len_limit}) begin
          start_skip();
          r.kind = EV_ERROR;
          r.err  = ERR_OVERSIZE;
          return 1'b1;
        end
        if (hdr_op == OP_PING || hdr_op == OP_PONG) begin
          if (len_left != '0) return 1'b0;
          parse_ph = PH_HDR0;
          r.kind   = (hdr_op == OP_PING) ? EV_PING : EV_PONG;
          return 1'b1;
        end
        if (hdr_op == OP_CONT && !frag_open) begin
          start_skip();
          r.kind = EV_ERROR;
          r.err  = ERR_CONT;
          return 1'b1;
        end
        if (hdr_op == OP_CLOSE) begin
          msg_cls = MT_CLOSE;
          if (len_left != '0) return 1'b0;
          parse_ph    = PH_HDR0;
          conn_closed = 1'b1;
          r.kind      = EV_CLOSED;
          r.mtype     = MT_CLOSE;
          r.msg_end   = 1'b1;
          return 1'b1;
        end
        // text, binary or a continuation of an open message
        if (hdr_op == OP_TEXT) msg_cls = MT_TEXT;
        else if (hdr_op == OP_BIN) msg_cls = MT_BIN;
        frag_open = !hdr_fin;
        if (len_left == '0) begin
          parse_ph = PH_HDR0;
          if (hdr_fin) begin
            r.mtype   = msg_cls;
            r.msg_end = 1'b1;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        if (len_left == '0) begin
          parse_ph = PH_HDR0;
          return 1'b0;
        end
        len_left = len_left - 64'd1;
        last     = (len_left == '0);
        if (last) parse_ph = PH_HDR0;
        if (skip_body) begin
          if (last) skip_body = 1'b0;
          return 1'b0;
        end
        // ping/pong payload is dropped, event on its last byte
        if (hdr_op == OP_PING || hdr_op == OP_PONG) begin
          r.kind = (hdr_op == OP_PING) ? EV_PING : EV_PONG;
          return last;
        end
        r.data    = b ^ mask_word[8*(3-key_pos) +: 8];
        r.present = 1'b1;
        key_pos   = key_pos + 2'd1;
        if (hdr_op == OP_CLOSE) begin
          r.mtype = MT_CLOSE;
          if (last) begin
            conn_closed = 1'b1;
            r.kind      = EV_CLOSED;
            r.msg_end   = 1'b1;
          end
          return 1'b1;
        end
        r.mtype   = msg_cls;
        r.msg_end = last && hdr_fin;
        return 1'b1;
      end
      default: begin
        parse_ph = PH_HDR0;
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed = 1'b0,
                                  input deframe_result_t res = NO_RESULT);
    script.push_back('{b, typed, res});
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
      mismatches++;
    end
  endfunction

  // Small lengths mostly; a few need the 16-bit form; some sit on a limit under 400
  function automatic logic [63:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 64'($urandom_range(0, 12));
    if (roll < 85) return 64'($urandom_range(13, 125));
    if (roll < 90) return 64'($urandom_range(126, 300));
    if (len_limit < 63'd400) return {1'b0, len_limit} + 64'($urandom_range(0, 1));
    return 64'($urandom_range(0, 4));
  endfunction

  // One byte transaction on the input channel. Valid stays high after the
  // transaction, so back-to-back bytes never drop it for a step.
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input deframe_result_t res = NO_RESULT);
    int unsigned     gap;
    deframe_result_t got;
    bit              hit;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    hit = deframe_byte(b, got);
    if (typed) rx_events_due.push_back(res);
    else if (hit) rx_events_due.push_back(got);
    bytes_sent++;
  endtask

  // Whole frame: header, length in a random legal form, key, payload
  task automatic send_frame(input logic [3:0] opc, input bit fin, input logic [63:0] len,
                            input bit rsv = 1'b0, input bit masked = 1'b1);
    logic [31:0] key;
    logic [2:0]  rbits;
    int unsigned enc;
    int unsigned pick;
    int unsigned body;
    key   = $urandom();
    rbits = rsv ? 3'($urandom_range(1, 7)) : 3'b000;
    if (len > 64'd65535) begin
      enc = 2;
    end else if (len > 64'd125) begin
      enc = ($urandom_range(0, 3) == 0) ? 2 : 1;
    end else begin
      pick = $urandom_range(0, 9);
      enc  = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
    end
    push_byte({fin, rbits, opc});
    case (enc)
      0: push_byte({masked, len[6:0]});
      1: begin
        push_byte({masked, LEN_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, LEN_EXT64});
        for (int k = 7; k >= 0; k--) push_byte(len[8*k +: 8]);
      end
    endcase
    for (int k = 3; k >= 0; k--) push_byte(key[8*k +: 8]);
    body = (len <= 64'd4096) ? int'(len) : 0;   // huge lengths: header only
    repeat (body) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Idle point: valid low, all owed results in, pipeline given time to settle
  task automatic drain();
    int unsigned guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (rx_events_due.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [62:0] v);
    cfg_valid_i              <= 1'b1;
    cfg_max_payload_length_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    len_limit = v;
  endtask

  // Output side: random stall before every transaction, then check it
  initial begin : result_sink
    int unsigned     hold;
    deframe_result_t want;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      kind_seen[event_kind_o]++;
      if (rx_events_due.size() == 0) begin
        $display("%0t: result with nothing owed, kind %0h data %0h err %0h", $time,
                 event_kind_o, payload_data_o, error_code_o);
        mismatches++;
      end else begin
        want = rx_events_due.pop_front();
        check_field("event_kind", 8'(want.kind), 8'(event_kind_o));
        check_field("payload_data", want.data, payload_data_o);
        check_field("data_present", 8'(want.present), 8'(data_present_o));
        check_field("message_type", 8'(want.mtype), 8'(message_type_o));
        check_field("message_end", 8'(want.msg_end), 8'(message_end_o));
        check_field("error_code", 8'(want.err), 8'(error_code_o));
      end
    end
  end

  initial begin : stimulus
    logic [62:0] plan [6];
    logic [63:0] len;
    logic [3:0]  opc;
    int unsigned roll;
    int unsigned pick;
    int unsigned budget;
    string       closing;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script, reset limit. Zero or all-ones keys on the data frames keep the data readable.
    // Continuation with no message open: error, nothing to skip
    add_row(8'h80); add_row(8'h80);
    add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h00, 1'b1, '{EV_ERROR, 8'h00, 1'b0, MT_TEXT, 1'b0, ERR_CONT});
    // Reserved opcode 0xF with FIN clear
    add_row(8'h0F); add_row(8'h80);
    add_row(8'h5A); add_row(8'hA5); add_row(8'h3C);
    add_row(8'hC3, 1'b1, '{EV_ERROR, 8'h00, 1'b0, MT_TEXT, 1'b0, ERR_OPCODE});
    // Empty ping, FIN clear is tolerated on control frames
    add_row(8'h09); add_row(8'h80);
    add_row(8'h12); add_row(8'h34); add_row(8'h56);
    add_row(8'h78, 1'b1, '{EV_PING, 8'h00, 1'b0, MT_TEXT, 1'b0, ERR_NONE});
    // First fragment of a text message, one byte under an all-ones key
    add_row(8'h01); add_row(8'h81);
    add_row(8'hFF); add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
    add_row(8'h00, 1'b1, '{EV_DATA, 8'hFF, 1'b1, MT_TEXT, 1'b0, ERR_NONE});
    // Empty final continuation closes the message with no data byte
    add_row(8'h80); add_row(8'h80);
    add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h00, 1'b1, '{EV_DATA, 8'h00, 1'b0, MT_TEXT, 1'b1, ERR_NONE});
    foreach (script[i]) push_byte(script[i].b, script[i].typed, script[i].res);
    drain();

    // Random frames under a run of length limits, both extremes included
    plan = '{63'd125, 63'd0, 63'd126, 63'd1, 63'($urandom_range(2, 600)), {63{1'b1}}};
    foreach (plan[p]) begin
      write_limit(plan[p]);
      budget = bytes_sent + 115;
      while (bytes_sent < budget) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          // data frames; continuations while a message is open
          opc = (frag_open && $urandom_range(0, 2) != 0) ? OP_CONT :
                ($urandom_range(0, 1) ? OP_TEXT : OP_BIN);
          send_frame(opc, $urandom_range(0, 3) != 0, pick_len());
        end else if (roll < 65) begin
          send_frame($urandom_range(0, 1) ? OP_PING : OP_PONG, $urandom_range(0, 4) != 0,
                     64'($urandom_range(0, 20)));
        end else if (roll < 73) begin
          send_frame(OP_CONT, 1'($urandom_range(0, 1)), 64'($urandom_range(0, 6)));
        end else if (roll < 83) begin
          // opcodes 3..7 and B..F are not supported
          pick = $urandom_range(0, 9);
          opc  = (pick < 5) ? 4'(3 + pick) : 4'(6 + pick);
          send_frame(opc, 1'($urandom_range(0, 1)), 64'($urandom_range(0, 10)));
        end else if (roll < 93 && len_limit < 63'd400) begin
          len = {1'b0, len_limit} + 64'($urandom_range(1, 3));
          send_frame($urandom_range(0, 1) ? OP_TEXT : OP_BIN, 1'b1, len);
        end else begin
          send_frame($urandom_range(0, 1) ? OP_TEXT : OP_BIN, 1'($urandom_range(0, 1)), 64'd0);
        end
      end
      drain();
    end

    // Closing the connection is sticky, so only one ending per run
    case ($urandom_range(0, 4))
      0: begin
        closing = "a close frame with payload";
        send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 64'($urandom_range(1, 20)));
      end
      1: begin
        closing = "an empty close frame";
        send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 64'd0);
      end
      2: begin
        closing = "an unmasked frame";
        send_frame(OP_TEXT, 1'b1, 64'd4, 1'b0, 1'b0);
      end
      3: begin
        closing = "reserved bits set";
        send_frame(OP_BIN, 1'b1, 64'd4, 1'b1);
      end
      default: begin
        closing = "a 64-bit length with its top bit set";
        send_frame(OP_BIN, 1'b1, {1'b1, 63'($urandom())});
      end
    endcase
    // Trailing bytes must vanish: closed, or still skipping the huge payload
    repeat (16) push_byte(8'($urandom_range(0, 255)));
    drain();

    if (rx_events_due.size() != 0) begin
      $display("%0t: %0d owed results never arrived", $time, rx_events_due.size());
      mismatches++;
    end
    $display("Sent %0d bytes, %0d results: %0d data, %0d ping, %0d pong, %0d error, %0d close",
             bytes_sent, results_seen, kind_seen[EV_DATA], kind_seen[EV_PING],
             kind_seen[EV_PONG], kind_seen[EV_ERROR], kind_seen[EV_CLOSED]);
    $display("Length limit taken through six settings from 0 to 2^63-1, ended by %s", closing);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
